>>> rtl/stp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and joint tables for the servo trajectory engine
package stp_pkg;

    // joint count and joint index width
    localparam int JOINTS = 8;
    localparam int JW     = 3;

    // request opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_POS    = 2'd2;

    // interpolation divider: one quotient bit per step, k runs 0..256
    localparam int DIV_STEPS = 9;
    localparam int CNT_W     = 4;

    // output angle window in degrees and pulse offset in counts
    localparam logic signed [9:0] DEG_LO   = -10'sd5;
    localparam logic signed [9:0] DEG_HI   = 10'sd185;
    localparam logic [11:0]       SERVO_LO = 12'd90;

    // (d+5)*455/190 done as (d+5) * ceil(91 * 2^16 / 38) >> 16, exact for d+5 <= 190
    localparam logic [17:0] SCALE_MUL   = 18'd156942;
    localparam int          SCALE_SHIFT = 16;
    localparam int          SPAN_W      = 9;

    // request payload
    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        joint;
        logic signed [7:0] angle;
        logic [15:0]       duration_ms;
        logic [31:0]       now_ms;
    } t_req;

    // result payload
    typedef struct packed {
        logic [2:0]  joint_index;
        logic [2:0]  pwm_channel;
        logic [11:0] on_count;
        logic [11:0] off_count;
        logic        last;
    } t_rsp;

    // commands from the controller to the datapath
    typedef struct packed {
        logic          latch;
        logic          wr_target;
        logic          div_load;
        logic          div_step;
        logic          mul;
        logic          interp;
        logic          clamp;
        logic          wr_end;
        logic          scale;
        logic          last;
        logic [JW-1:0] jidx;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic active;
    } t_dp_stat;

    // joint to driver channel
    function automatic logic [2:0] chan_map(input logic [2:0] j);
        logic [2:0] c;
        unique case (j)
            3'd0: c = 3'd1;
            3'd1: c = 3'd0;
            3'd2: c = 3'd5;
            3'd3: c = 3'd4;
            3'd4: c = 3'd3;
            3'd5: c = 3'd2;
            3'd6: c = 3'd7;
            default: c = 3'd6;
        endcase
        return c;
    endfunction

    // servo mounted reversed
    function automatic logic pol_neg(input logic [2:0] j);
        logic p;
        unique case (j)
            3'd1, 3'd3, 3'd4, 3'd6: p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

    // neutral position in degrees
    function automatic logic [7:0] neutral(input logic [2:0] j);
        logic [7:0] n;
        unique case (j)
            3'd0: n = 8'd79;
            3'd1: n = 8'd90;
            3'd2: n = 8'd77;
            default: n = 8'd94;
        endcase
        return n;
    endfunction

    // mechanical lower limit
    function automatic logic signed [7:0] lim_lo(input logic [2:0] j);
        logic signed [7:0] v;
        unique case (j)
            3'd1, 3'd5: v = -8'sd55;
            3'd3, 3'd7: v = -8'sd90;
            default: v = -8'sd35;
        endcase
        return v;
    endfunction

    // mechanical upper limit
    function automatic logic signed [7:0] lim_hi(input logic [2:0] j);
        logic signed [7:0] v;
        unique case (j)
            3'd1, 3'd5: v = 8'sd60;
            3'd3, 3'd7: v = 8'sd45;
            default: v = 8'sd100;
        endcase
        return v;
    endfunction

    // index of the lowest set bit
    function automatic logic [JW-1:0] lowest_set(input logic [JOINTS-1:0] m);
        logic [JW-1:0] idx;
        idx = '0;
        for (int i = JOINTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = JW'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/stp_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: request sequencing, joint scan and divider stepping
module stp_ctrl
    import stp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    input  logic [JW-1:0] i_joint,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  t_dp_stat      i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TARGET = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DIVLD  = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ANGLE  = 4'd6;
    localparam logic [3:0] S_CLAMP  = 4'd7;
    localparam logic [3:0] S_SCALE  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [JW-1:0]     r_jidx, n_jidx;
    logic [JOINTS-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pos, n_pos;

    logic [JOINTS-1:0] onehot;
    logic [JOINTS-1:0] mask_scan;
    logic [JOINTS-1:0] mask_rest;
    t_dp_cmd           cmd;

    // mask views for the current joint
    assign onehot    = {{(JOINTS-1){1'b0}}, 1'b1} << r_jidx;
    assign mask_scan = i_stat.active ? (r_mask | onehot) : r_mask;
    assign mask_rest = r_mask & ~onehot;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_jidx   = r_jidx;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        cmd      = '0;
        cmd.jidx = r_jidx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_jidx    = i_joint;
                    n_pos     = (i_op == OP_POS);
                    unique case (i_op)
                        OP_TICK: begin
                            n_jidx  = '0;
                            n_mask  = '0;
                            n_state = S_SCAN;
                        end
                        OP_TARGET: n_state = S_TARGET;
                        OP_POS:    n_state = S_CLAMP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TARGET: begin
                cmd.wr_target = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                n_mask = mask_scan;
                if (r_jidx == JW'(JOINTS - 1)) begin
                    if (mask_scan == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_jidx  = lowest_set(mask_scan);
                        n_state = S_DIVLD;
                    end
                end else begin
                    n_jidx = r_jidx + 1'b1;
                end
            end
            S_DIVLD: begin
                cmd.div_load = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ANGLE;
            end
            S_ANGLE: begin
                cmd.interp = 1'b1;
                n_state    = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp  = 1'b1;
                cmd.wr_end = r_pos;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                cmd.last  = r_pos || (mask_rest == '0);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_mask = mask_rest;
                    if (r_pos || (mask_rest == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_jidx  = lowest_set(mask_rest);
                        n_state = S_DIVLD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_jidx  <= '0;
            r_mask  <= '0;
            r_cnt   <= '0;
            r_pos   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_jidx  <= n_jidx;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    // handshake outputs
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd       = cmd;

endmodule

>>> rtl/stp_dp.sv
`timescale 1ns / 1ps
// datapath: joint state, calibration, serial divider, interpolation and pulse scaling
module stp_dp
    import stp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [JW-1:0] i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  t_req          i_req,
    input  t_dp_cmd       i_cmd,
    output t_dp_stat      o_stat,
    output t_rsp          o_rsp
);

    // per-joint state and calibration
    logic signed [7:0] r_calib [JOINTS];
    logic signed [7:0] r_cur   [JOINTS];
    logic signed [7:0] r_start [JOINTS];
    logic signed [7:0] r_end   [JOINTS];
    logic [31:0]       r_stime [JOINTS];
    logic [15:0]       r_mdur  [JOINTS];

    // latched request and working registers
    logic signed [7:0]  r_angle;
    logic [15:0]        r_dur;
    logic [31:0]        r_now;
    logic [16:0]        r_rem;
    logic [DIV_STEPS-1:0] r_quo;
    logic signed [18:0] r_prod;
    logic signed [7:0]  r_deg;
    logic [7:0]         r_dpos;
    t_rsp               r_rsp;

    logic [JW-1:0]      j;
    logic [31:0]        elapsed;
    logic [15:0]        dur_j;
    logic               ge;
    logic [16:0]        rem_sub;
    logic signed [7:0]  st_ang, en_ang, cal, lo, hi, dc;
    logic signed [SPAN_W-1:0] span;
    logic signed [9:0]  kq;
    logic signed [18:0] prod_full, shifted, ang_full;
    logic signed [9:0]  sum, polv, dn, dcl, dpos_full;
    logic [25:0]        sprod;
    logic [8:0]         width_q;
    logic [11:0]        on_cnt, off_cnt;

    assign j       = i_cmd.jidx;
    assign dur_j   = r_mdur[j];
    assign st_ang  = r_start[j];
    assign en_ang  = r_end[j];
    assign cal     = r_calib[j];

    // moving test: nonzero duration and elapsed time within it
    assign elapsed       = r_now - r_stime[j];
    assign o_stat.active = (dur_j != 16'd0) && (elapsed <= {16'd0, dur_j});

    // restoring divider step for k = elapsed*256/duration
    assign ge      = (r_rem >= {1'b0, dur_j});
    assign rem_sub = ge ? (r_rem - {1'b0, dur_j}) : r_rem;

    // span times k, then floor shift and add to start
    assign span      = {en_ang[7], en_ang} - {st_ang[7], st_ang};
    assign kq        = {1'b0, r_quo};
    assign prod_full = span * kq;
    assign shifted   = r_prod >>> 8;
    assign ang_full  = {{11{st_ang[7]}}, st_ang} + shifted;

    // joint limits, calibration, polarity, neutral, output window
    assign lo   = lim_lo(j);
    assign hi   = lim_hi(j);
    assign dc   = (r_deg > hi) ? hi : ((r_deg < lo) ? lo : r_deg);
    assign sum  = {{2{dc[7]}}, dc} + {{2{cal[7]}}, cal};
    assign polv = pol_neg(j) ? -sum : sum;
    assign dn   = polv + {2'b00, neutral(j)};
    assign dcl  = (dn > DEG_HI) ? DEG_HI : ((dn < DEG_LO) ? DEG_LO : dn);
    assign dpos_full = dcl - DEG_LO;

    // pulse width scaling and staggered on/off counts
    assign sprod   = {18'd0, r_dpos} * {8'd0, SCALE_MUL};
    assign width_q = sprod[SCALE_SHIFT +: 9];
    assign on_cnt  = {j, 9'd0};
    assign off_cnt = on_cnt + {3'd0, width_q} + SERVO_LO;

    // joint state and calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINTS; i++) begin
                r_calib[i] <= '0;
                r_cur[i]   <= '0;
                r_start[i] <= '0;
                r_end[i]   <= '1;
                r_stime[i] <= '0;
                r_mdur[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_calib[i_cfg_idx] <= i_cfg_data;
            end
            if (i_cmd.wr_target) begin
                r_stime[j] <= r_now;
                r_mdur[j]  <= r_dur;
                r_start[j] <= r_cur[j];
                r_end[j]   <= r_angle;
            end
            if (i_cmd.clamp) begin
                r_cur[j] <= r_deg;
            end
            if (i_cmd.wr_end) begin
                r_end[j] <= r_deg;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_angle <= i_req.angle;
            r_dur   <= i_req.duration_ms;
            r_now   <= i_req.now_ms;
            r_deg   <= i_req.angle;
        end
        if (i_cmd.div_load) begin
            r_rem <= {1'b0, elapsed[15:0]};
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {rem_sub[15:0], 1'b0};
            r_quo <= {r_quo[DIV_STEPS-2:0], ge};
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full;
        end
        if (i_cmd.interp) begin
            r_deg <= ang_full[7:0];
        end
        if (i_cmd.clamp) begin
            r_dpos <= dpos_full[7:0];
        end
        if (i_cmd.scale) begin
            r_rsp.joint_index <= j;
            r_rsp.pwm_channel <= chan_map(j);
            r_rsp.on_count    <= on_cnt;
            r_rsp.off_count   <= off_cnt;
            r_rsp.last        <= i_cmd.last;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> rtl/servo_trajectory_pwm.sv
`timescale 1ns / 1ps
// top level of the eight-joint servo trajectory engine with pwm pulse output
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  request  | i_in_valid / o_in_ready    | i_in_req  (t_req)
//  result   | o_out_valid / i_out_ready  | o_out_rsp (t_rsp)
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// set position gives its result through the clamp, scale and output states.
// a tick scans all eight joints, then for each moving joint runs the divider,
// multiply, interpolate, clamp and scale states, one quotient bit per cycle over 9 steps.
// one request at a time; each result waits in the output register until taken.
// synchronous active-low reset clears joint state and calibration at once.
module servo_trajectory_pwm
    import stp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_req          i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_rsp          o_out_rsp,
    input  logic          i_cfg_we,
    input  logic [JW-1:0] i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller
    stp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_in_req.op),
        .i_joint     (i_in_req.joint),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    stp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in_req),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_rsp      (o_out_rsp)
    );

endmodule

>>> rtl/stp_checker.sv
`timescale 1ns / 1ps
// port-level checker for the servo trajectory engine, bound to the top level
module stp_checker
    import stp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_req,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // no new request while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while result pending");

    // set position answers with a single last result for its joint
    a_pos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_req.op == OP_POS) |->
        ##3 (o_out_valid && o_out_rsp.last
             && o_out_rsp.joint_index == $past(i_in_req.joint, 3)))
        else $error("set position result missing or wrong");

    // set target gives no result and frees the request side again
    a_target_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_req.op == OP_TARGET) |=>
        (!o_out_valid ##1 o_in_ready))
        else $error("set target misbehaved");

endmodule

bind servo_trajectory_pwm stp_checker u_stp_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the eight-joint servo trajectory engine
module testbench;
    import stp_pkg::*;

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // run control
    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 3000;

    // calibration settings
    localparam int CAL_ZERO  = 0;
    localparam int CAL_LOW   = 1;
    localparam int CAL_HIGH  = 2;
    localparam int CAL_MIXED = 3;

    // receiver stall patterns
    localparam int SINK_OPEN   = 0;
    localparam int SINK_RANDOM = 1;
    localparam int SINK_THIRD  = 2;
    localparam int SINK_BURSTY = 3;

    // servo scaling
    localparam int OUT_DEG_MIN = -5;
    localparam int OUT_DEG_MAX = 185;
    localparam int PULSE_MIN   = 90;
    localparam int PULSE_SPAN  = 455;
    localparam int STAGGER     = 512;

    // per-joint tables, joint 7 in the top slot
    localparam logic [23:0] CHAN_TAB   = {3'd6, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1};
    localparam logic [7:0]  POL_NEG    = 8'b0101_1010;
    localparam logic [63:0] NEUT_TAB   = {8'd94, 8'd94, 8'd94, 8'd94,
                                          8'd94, 8'd77, 8'd90, 8'd79};
    localparam logic [63:0] LIM_LO_TAB = {-8'sd90, -8'sd35, -8'sd55, -8'sd35,
                                          -8'sd90, -8'sd35, -8'sd55, -8'sd35};
    localparam logic [63:0] LIM_HI_TAB = {8'sd45, 8'sd100, 8'sd60, 8'sd100,
                                          8'sd45, 8'sd100, 8'sd60, 8'sd100};

    // block ports
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    t_req          i_in_req    = '0;
    logic          i_out_ready = 1'b0;
    logic          i_cfg_we    = 1'b0;
    logic [JW-1:0] i_cfg_idx   = '0;
    logic [7:0]    i_cfg_data  = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    t_rsp          o_out_rsp;

    // predicted joint state and calibration
    int          jt_calib   [JOINTS];
    int          jt_current [JOINTS];
    int          jt_start   [JOINTS];
    int          jt_end     [JOINTS];
    logic [31:0] jt_t0      [JOINTS];
    logic [15:0] jt_dur     [JOINTS];

    // pulse updates still owed by the block, oldest first
    t_rsp pwm_expected [$];

    // bookkeeping
    int   err_count    = 0;
    int   req_count    = 0;
    int   n_ticks      = 0;
    int   n_targets    = 0;
    int   n_positions  = 0;
    int   n_unused     = 0;
    int   n_pulses     = 0;
    int   cfg_writes   = 0;
    int   cfg_settings = 0;
    int   burst_left   = 0;
    bit   req_up       = 1'b0;
    logic [31:0] sim_ms = 32'd50;

    // receiver pattern and watchdog state
    int sink_cycle   = 0;
    int sink_mode    = SINK_OPEN;
    int stall_left   = 0;
    int quiet_cycles = 0;

    servo_trajectory_pwm uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // count and print one mismatch
    task automatic report_err(input string what);
        err_count++;
        if (err_count <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // pulse pair for one joint driven to an angle
    function automatic t_rsp servo_pulse(input int j, input int deg, input logic fin);
        int   lo;
        int   hi;
        int   pos;
        int   d;
        t_rsp p;
        lo  = int'($signed(LIM_LO_TAB[j*8 +: 8]));
        hi  = int'($signed(LIM_HI_TAB[j*8 +: 8]));
        pos = deg;
        if (pos > hi) begin
            pos = hi;
        end else if (pos < lo) begin
            pos = lo;
        end
        d = pos + jt_calib[j];
        if (POL_NEG[j]) begin
            d = -d;
        end
        d = d + int'(NEUT_TAB[j*8 +: 8]);
        if (d > OUT_DEG_MAX) begin
            d = OUT_DEG_MAX;
        end else if (d < OUT_DEG_MIN) begin
            d = OUT_DEG_MIN;
        end
        p.joint_index = 3'(j);
        p.pwm_channel = CHAN_TAB[j*3 +: 3];
        p.on_count    = 12'(STAGGER * j);
        p.off_count   = 12'(STAGGER * j + (d - OUT_DEG_MIN) * PULSE_SPAN
                            / (OUT_DEG_MAX - OUT_DEG_MIN) + PULSE_MIN);
        p.last        = fin;
        return p;
    endfunction

    // advance the predicted state by one accepted request
    function automatic void model_request(input t_req r);
        logic [31:0]       el;
        logic [JOINTS-1:0] hit;
        int                ang_now [JOINTS];
        int                i;
        int                j;
        int                k;
        int                tail;
        int                ang;
        j    = int'(r.joint);
        ang  = int'($signed(r.angle));
        hit  = '0;
        tail = 0;
        case (r.op)
            OP_TICK: begin
                n_ticks++;
                // interpolate every joint still inside its move window
                for (i = 0; i < JOINTS; i++) begin
                    el = r.now_ms - jt_t0[i];
                    ang_now[i] = 0;
                    if (jt_dur[i] != 16'd0 && el <= {16'd0, jt_dur[i]}) begin
                        k = int'((el * 32'd256) / {16'd0, jt_dur[i]});
                        ang_now[i] = jt_start[i] + (((jt_end[i] - jt_start[i]) * k) >>> 8);
                        hit[i] = 1'b1;
                        tail = i;
                    end
                end
                for (i = 0; i < JOINTS; i++) begin
                    if (hit[i]) begin
                        jt_current[i] = ang_now[i];
                        pwm_expected.push_back(servo_pulse(i, ang_now[i], i == tail));
                    end
                end
            end
            OP_TARGET: begin
                n_targets++;
                jt_t0[j]    = r.now_ms;
                jt_dur[j]   = r.duration_ms;
                jt_start[j] = jt_current[j];
                jt_end[j]   = ang;
            end
            OP_POS: begin
                n_positions++;
                jt_current[j] = ang;
                jt_end[j]     = ang;
                pwm_expected.push_back(servo_pulse(j, ang, 1'b1));
            end
            default: begin
                n_unused++;
            end
        endcase
    endfunction

    function automatic t_req mk_req(input logic [1:0] op, input int joint, input int angle,
                                    input int dur, input logic [31:0] now);
        t_req r;
        r.op          = op;
        r.joint       = 3'(joint);
        r.angle       = 8'(angle);
        r.duration_ms = 16'(dur);
        r.now_ms      = now;
        return r;
    endfunction

    // send one request, in bursts with random gaps between them
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
        end
        if (gap > 0 || !req_up) begin
            if (req_up) begin
                i_in_valid <= 1'b0;
            end
            req_up = 1'b0;
            repeat ((gap > 0) ? gap : 1) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        req_up = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model_request(r);
        if (r.op != OP_UNUSED) begin
            req_count++;
        end
    endtask

    // stop sending and wait for every owed pulse update
    task automatic drain_results();
        if (req_up) begin
            i_in_valid <= 1'b0;
        end
        req_up = 1'b0;
        while (pwm_expected.size() != 0) @(posedge i_clk);
    endtask

    // drained, and a tick that drives nothing has had time to finish
    task automatic settle_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all eight calibration registers
    task automatic load_calibration(input int mode);
        int         i;
        logic [7:0] v;
        settle_idle();
        for (i = 0; i < JOINTS; i++) begin
            case (mode)
                CAL_ZERO: v = 8'sh00;
                CAL_LOW:  v = 8'sh80;
                CAL_HIGH: v = 8'sh7F;
                default:  v = 8'($urandom_range(0, 255));
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= JW'(i);
            i_cfg_data <= v;
            @(posedge i_clk);
            jt_calib[i] = int'($signed(v));
            cfg_writes++;
        end
        i_cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    // a group of joints given moves, then ticks sweeping through them
    task automatic run_move();
        logic [31:0] t0;
        int          nj;
        int          j;
        int          dur;
        int          pick;
        int          longest;
        int          span;
        int          step;
        int          off;
        t0      = ($urandom_range(0, 15) == 0) ? $urandom() : sim_ms;
        nj      = $urandom_range(1, JOINTS);
        longest = 0;
        repeat (nj) begin
            j    = $urandom_range(0, JOINTS - 1);
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                dur = 0;
            end else if (pick < 5) begin
                dur = $urandom_range(41, 65535);
            end else begin
                dur = $urandom_range(1, 40);
            end
            if (dur > longest) begin
                longest = dur;
            end
            send_request(mk_req(OP_TARGET, j, $urandom_range(0, 255), dur,
                                t0 + $urandom_range(0, 2)));
        end
        span = longest + 3;
        step = span / $urandom_range(3, 12) + 1;
        off  = 0;
        while (off <= span) begin
            // now and then a joint is forced mid-move
            if ($urandom_range(0, 9) == 0) begin
                send_request(mk_req(OP_POS, $urandom_range(0, 7), $urandom_range(0, 255),
                                    $urandom_range(0, 65535), $urandom()));
            end
            send_request(mk_req(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                                $urandom_range(0, 65535), t0 + off));
            off = off + $urandom_range(1, step);
        end
        sim_ms = t0 + off + $urandom_range(1, 100);
    endtask

    // mostly well-formed moves, some requests with every field random
    task automatic run_traffic(input int n_items);
        int goal;
        goal = req_count + n_items;
        while (req_count < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                run_move();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(mk_req(2'($urandom_range(int'(OP_TICK), int'(OP_UNUSED))),
                                        $urandom_range(0, 7), $urandom_range(0, 255),
                                        $urandom_range(0, 65535), $urandom()));
                end
            end
        end
    endtask

    // field extremes, every opcode, wrap of the millisecond counter
    task automatic test_directed();
        int j;
        // set position at the angle extremes, both polarities
        send_request(mk_req(OP_POS, 0, 127, 0, 0));
        send_request(mk_req(OP_POS, 1, -128, 0, 0));
        send_request(mk_req(OP_POS, 3, -90, 65535, 32'hFFFF_FFFF));
        // unused opcode leaves the state alone
        send_request(mk_req(OP_UNUSED, 5, 99, 1234, 32'h1234_5678));
        // zero duration keeps the joint idle, tick drives nothing
        send_request(mk_req(OP_TARGET, 2, -128, 0, 100));
        send_request(mk_req(OP_TICK, 0, 0, 0, 100));
        // moves straddling the 32-bit wrap of the time
        send_request(mk_req(OP_TARGET, 0, -128, 65535, 32'hFFFF_FF00));
        send_request(mk_req(OP_TARGET, 3, 127, 1, 32'hFFFF_FFFF));
        send_request(mk_req(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(mk_req(OP_TICK, 0, 0, 0, 32'h0000_0000));
        send_request(mk_req(OP_TICK, 0, 0, 0, 32'h0000_0001));
        // set position during a move changes where the move ends
        send_request(mk_req(OP_TARGET, 7, 127, 10, 5));
        send_request(mk_req(OP_POS, 7, -100, 0, 0));
        send_request(mk_req(OP_TICK, 7, 0, 0, 10));
        send_request(mk_req(OP_TICK, 7, 0, 0, 15));
        // longest duration reached exactly
        send_request(mk_req(OP_TICK, 0, 0, 0, 32'h0000_FEFF));
        // all joints moving on one tick
        for (j = 0; j < JOINTS; j++) begin
            send_request(mk_req(OP_TARGET, j, (j % 2 != 0) ? 127 : -128, 4, 2000));
        end
        send_request(mk_req(OP_TICK, 0, 0, 0, 2003));
    endtask

    task automatic test_calib_low();
        load_calibration(CAL_LOW);
        run_traffic(65);
    endtask

    task automatic test_calib_high();
        load_calibration(CAL_HIGH);
        run_traffic(65);
    endtask

    // random calibration, with a full drain partway through
    task automatic test_calib_mixed();
        load_calibration(CAL_MIXED);
        run_traffic(40);
        drain_results();
        run_traffic(35);
        load_calibration(CAL_MIXED);
        run_traffic(75);
    endtask

    task automatic test_calib_zero();
        load_calibration(CAL_ZERO);
        run_traffic(65);
    endtask

    // receiver readiness, with a pattern picked at random
    always @(posedge i_clk) begin : sink_pattern
        if (sink_cycle % 256 == 0) begin
            sink_mode = $urandom_range(SINK_OPEN, SINK_BURSTY);
        end
        sink_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN:   i_out_ready <= 1'b1;
                SINK_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
                SINK_THIRD:  i_out_ready <= (sink_cycle % 3 == 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 30);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // compare each accepted pulse update with the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_pulses++;
            if (pwm_expected.size() == 0) begin
                report_err($sformatf("unexpected result joint %0d", o_out_rsp.joint_index));
            end else begin
                want = pwm_expected.pop_front();
                if (o_out_rsp.joint_index !== want.joint_index) begin
                    report_err($sformatf("joint_index got %0d want %0d",
                                         o_out_rsp.joint_index, want.joint_index));
                end
                if (o_out_rsp.pwm_channel !== want.pwm_channel) begin
                    report_err($sformatf("pwm_channel got %0d want %0d (joint %0d)",
                                         o_out_rsp.pwm_channel, want.pwm_channel,
                                         want.joint_index));
                end
                if (o_out_rsp.on_count !== want.on_count) begin
                    report_err($sformatf("on_count got %0d want %0d (joint %0d)",
                                         o_out_rsp.on_count, want.on_count,
                                         want.joint_index));
                end
                if (o_out_rsp.off_count !== want.off_count) begin
                    report_err($sformatf("off_count got %0d want %0d (joint %0d)",
                                         o_out_rsp.off_count, want.off_count,
                                         want.joint_index));
                end
                if (o_out_rsp.last !== want.last) begin
                    report_err($sformatf("last got %0b want %0b (joint %0d)",
                                         o_out_rsp.last, want.last, want.joint_index));
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // main sequence
    initial begin : main
        int i;
        for (i = 0; i < JOINTS; i++) begin
            jt_calib[i]   = 0;
            jt_current[i] = 0;
            jt_start[i]   = 0;
            jt_end[i]     = -1;
            jt_t0[i]      = '0;
            jt_dur[i]     = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_calib_low();
        test_calib_high();
        test_calib_mixed();
        test_calib_zero();

        settle_idle();
        if (pwm_expected.size() != 0) begin
            report_err($sformatf("%0d results never arrived", pwm_expected.size()));
        end
        $display("summary: %0d ticks, %0d targets, %0d set-positions, %0d unused opcodes",
                 n_ticks, n_targets, n_positions, n_unused);
        $display("summary: %0d pulse updates checked, %0d calibration writes over %0d settings",
                 n_pulses, cfg_writes, cfg_settings);
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/stp_pkg.sv
rtl/stp_ctrl.sv
rtl/stp_dp.sv
rtl/servo_trajectory_pwm.sv
rtl/stp_checker.sv
tb/testbench.sv
